/* hw/rtl/tsef_pkg.sv */
// ============================================================================
// tsef_pkg
// Shared constants, op codes, states and the controller command word for the
// three-spin energy and field block.
// ============================================================================
package tsef_pkg;

    // Default sizes
    localparam int SPIN_WIDTH     = 16;
    localparam int ACC_WIDTH      = 48;

    // Fixed formats
    localparam int COUP_WIDTH     = 16;
    localparam int COUP_RESET     = 256;
    localparam int COUP_FRAC      = 8;
    localparam int OUT_WIDTH      = 40;
    localparam int OUT_FRAC       = 24;
    localparam int DOT_WIDTH      = 27;   // |dot| <= 3.0 with 24 fraction bits
    localparam int ECELL_WIDTH    = 30;   // per-cell energy sum
    localparam int FCELL_WIDTH    = 29;   // per-cell field sum
    localparam int LIM_WIDTH      = 49;   // accumulator clamped to +-2^47
    localparam int LIM_EXP        = 47;
    localparam int SPLIT          = 24;   // low/high split of clamped value
    localparam int HI_WIDTH       = LIM_WIDTH - SPLIT;
    localparam int CA_WIDTH       = COUP_WIDTH + 1;  // coupling, negation safe
    localparam int HP_WIDTH       = CA_WIDTH + HI_WIDTH + 1;
    localparam int P_WIDTH        = HP_WIDTH + SPLIT;

    // APB
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;
    localparam logic REG_COUPLING = 1'b0;   // word index of the coupling reg

    // Multiplier jobs, in issue order
    typedef enum logic [4:0] {
        OP_IJ_X, OP_IJ_Y, OP_IJ_Z,
        OP_IK_X, OP_IK_Y, OP_IK_Z,
        OP_JK_X, OP_JK_Y, OP_JK_Z,
        OP_E_IJIK, OP_E_IJJK, OP_E_IKJK,
        OP_F_J_X, OP_F_K_X, OP_F_JK_X,
        OP_F_J_Y, OP_F_K_Y, OP_F_JK_Y,
        OP_F_J_Z, OP_F_K_Z, OP_F_JK_Z,
        OP_O_E_LO, OP_O_E_HI,
        OP_O_X_LO, OP_O_X_HI,
        OP_O_Y_LO, OP_O_Y_HI,
        OP_O_Z_LO, OP_O_Z_HI
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_DRAIN,
        S_COMMIT,
        S_WAIT_OUT,
        S_OUT,
        S_OUT_DRAIN
    } t_state;

    typedef struct packed {
        logic load;     // capture input word, clear per-cell sums
        logic issue;    // start a multiply for op
        t_op  op;
        logic commit;   // saturating add of cell sums into accumulators
        logic finish;   // publish result, clear accumulators
    } t_cmd;

endpackage

/* hw/rtl/tsef_cfg.sv */
// ============================================================================
// tsef_cfg
// APB register slave holding the coupling constant.
// ============================================================================
module tsef_cfg (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [tsef_pkg::APB_ADDR_WIDTH-1:0]     paddr,
    input  logic [tsef_pkg::APB_DATA_WIDTH-1:0]     pwdata,
    output logic [tsef_pkg::APB_DATA_WIDTH-1:0]     prdata,
    output logic                                    pready,
    output logic signed [tsef_pkg::COUP_WIDTH-1:0]  o_coupling
);

    logic signed [tsef_pkg::COUP_WIDTH-1:0] r_coupling;
    logic                                   sel_coup;

    assign sel_coup = (paddr[2] == tsef_pkg::REG_COUPLING);
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coupling <= tsef_pkg::COUP_WIDTH'(tsef_pkg::COUP_RESET);
        end else if (psel && penable && pwrite && sel_coup) begin
            r_coupling <= pwdata[tsef_pkg::COUP_WIDTH-1:0];
        end
    end

    always_comb begin
        if (sel_coup) begin
            prdata = tsef_pkg::APB_DATA_WIDTH'(r_coupling);
        end else begin
            prdata = '0;
        end
    end

    assign o_coupling = r_coupling;

endmodule

/* hw/rtl/tsef_ctrl.sv */
// ============================================================================
// tsef_ctrl
// Sequencer: steps the shared multiplier through the per-cell jobs and the
// output scaling jobs, and hands the datapath its command word.
// ============================================================================
module tsef_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_cell_valid,
    input  logic              i_last_cell,
    input  logic              i_out_busy,
    output logic              o_ready,
    output tsef_pkg::t_cmd    o_cmd
);

    tsef_pkg::t_state r_state, n_state;
    tsef_pkg::t_op    r_op, n_op;
    logic             r_last, n_last;
    tsef_pkg::t_op    op_inc;

    assign op_inc = tsef_pkg::t_op'(5'(r_op) + 5'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsef_pkg::S_IDLE;
            r_op    <= tsef_pkg::OP_IJ_X;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_last       = r_last;
        o_ready      = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.op     = r_op;
        o_cmd.commit = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            tsef_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_last     = i_last_cell;
                    n_op       = tsef_pkg::OP_IJ_X;
                    if (i_cell_valid) begin
                        n_state = tsef_pkg::S_CALC;
                    end else if (i_last_cell) begin
                        n_state = tsef_pkg::S_WAIT_OUT;
                    end
                end
            end
            tsef_pkg::S_CALC: begin
                o_cmd.issue = 1'b1;
                if (r_op == tsef_pkg::OP_F_JK_Z) begin
                    n_state = tsef_pkg::S_DRAIN;
                end else begin
                    n_op = op_inc;
                end
            end
            tsef_pkg::S_DRAIN: begin
                n_state = tsef_pkg::S_COMMIT;
            end
            tsef_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = r_last ? tsef_pkg::S_WAIT_OUT : tsef_pkg::S_IDLE;
            end
            tsef_pkg::S_WAIT_OUT: begin
                // result registers are rewritten in place, so wait for them
                if (!i_out_busy) begin
                    n_state = tsef_pkg::S_OUT;
                    n_op    = tsef_pkg::OP_O_E_LO;
                end
            end
            tsef_pkg::S_OUT: begin
                o_cmd.issue = 1'b1;
                if (r_op == tsef_pkg::OP_O_Z_HI) begin
                    n_state = tsef_pkg::S_OUT_DRAIN;
                end else begin
                    n_op = op_inc;
                end
            end
            tsef_pkg::S_OUT_DRAIN: begin
                o_cmd.finish = 1'b1;
                n_state      = tsef_pkg::S_IDLE;
            end
            default: begin
                n_state = tsef_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/tsef_dp.sv */
// ============================================================================
// tsef_dp
// Datapath: input word registers, one shared signed multiplier with a
// registered product, per-cell sums, saturating accumulators and the
// output scaling and saturation.
// ============================================================================
module tsef_dp #(
    parameter int SPIN_WIDTH = tsef_pkg::SPIN_WIDTH,
    parameter int ACC_WIDTH  = tsef_pkg::ACC_WIDTH
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  tsef_pkg::t_cmd                          i_cmd,
    input  logic signed [SPIN_WIDTH-1:0]            i_spin_i_x,
    input  logic signed [SPIN_WIDTH-1:0]            i_spin_i_y,
    input  logic signed [SPIN_WIDTH-1:0]            i_spin_i_z,
    input  logic signed [SPIN_WIDTH-1:0]            i_spin_j_x,
    input  logic signed [SPIN_WIDTH-1:0]            i_spin_j_y,
    input  logic signed [SPIN_WIDTH-1:0]            i_spin_j_z,
    input  logic signed [SPIN_WIDTH-1:0]            i_spin_k_x,
    input  logic signed [SPIN_WIDTH-1:0]            i_spin_k_y,
    input  logic signed [SPIN_WIDTH-1:0]            i_spin_k_z,
    input  logic signed [tsef_pkg::COUP_WIDTH-1:0]  i_coupling,
    input  logic                                    i_ready,
    output logic                                    o_valid,
    output logic                                    o_out_busy,
    output logic signed [tsef_pkg::OUT_WIDTH-1:0]   o_site_energy,
    output logic signed [tsef_pkg::OUT_WIDTH-1:0]   o_field_x,
    output logic signed [tsef_pkg::OUT_WIDTH-1:0]   o_field_y,
    output logic signed [tsef_pkg::OUT_WIDTH-1:0]   o_field_z
);

    localparam int SW1   = SPIN_WIDTH + 1;
    localparam int MW    = (SW1 > tsef_pkg::DOT_WIDTH) ? SW1 : tsef_pkg::DOT_WIDTH;
    localparam int PW    = 2 * MW;
    localparam int PFRAC = 2 * SPIN_WIDTH - 2;
    localparam int DSH_R = (PFRAC >= tsef_pkg::OUT_FRAC) ? PFRAC - tsef_pkg::OUT_FRAC : 0;
    localparam int DSH_L = (PFRAC <  tsef_pkg::OUT_FRAC) ? tsef_pkg::OUT_FRAC - PFRAC : 0;
    localparam int XW    = (ACC_WIDTH > tsef_pkg::LIM_WIDTH) ? ACC_WIDTH : tsef_pkg::LIM_WIDTH;
    localparam int OW    = tsef_pkg::OUT_WIDTH;
    localparam int QW    = tsef_pkg::P_WIDTH;

    localparam logic signed [XW-1:0] LIM_P = XW'(1) <<< tsef_pkg::LIM_EXP;
    localparam logic signed [XW-1:0] LIM_N = -LIM_P;
    localparam logic signed [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

    // input word
    logic signed [SPIN_WIDTH-1:0] r_mi_x, r_mi_y, r_mi_z;
    logic signed [SPIN_WIDTH-1:0] r_mj_x, r_mj_y, r_mj_z;
    logic signed [SPIN_WIDTH-1:0] r_mk_x, r_mk_y, r_mk_z;
    logic signed [SW1-1:0]        r_mjk_x, r_mjk_y, r_mjk_z;

    // per-cell sums
    logic signed [tsef_pkg::DOT_WIDTH-1:0]   r_dij, r_dik, r_djk;
    logic signed [tsef_pkg::ECELL_WIDTH-1:0] r_ecell;
    logic signed [tsef_pkg::FCELL_WIDTH-1:0] r_fx, r_fy, r_fz;

    // accumulators
    logic signed [ACC_WIDTH-1:0] r_acc_e, r_acc_x, r_acc_y, r_acc_z;

    // multiplier
    logic signed [MW-1:0] op_a, op_b;
    logic signed [PW-1:0] r_prod;
    tsef_pkg::t_op        r_pop;
    logic                 r_pvld;

    // output scaling
    logic signed [ACC_WIDTH-1:0]               sel_acc;
    logic                                      sel_neg;
    logic signed [XW-1:0]                      acc_x, acc_cl;
    logic signed [tsef_pkg::HI_WIDTH-1:0]      cl_lo, cl_hi;
    logic signed [tsef_pkg::CA_WIDTH-1:0]      coup_x, coup_a;
    logic signed [tsef_pkg::HP_WIDTH-1:0]      r_lo, hp;
    logic signed [QW-1:0]                      p_full, p_shr;
    logic [QW-OW:0]                            p_top;
    logic signed [OW-1:0]                      p_sat;

    logic signed [PW-1:0]                      dsh, esh, fsh;
    logic signed [tsef_pkg::DOT_WIDTH-1:0]     dot_term;
    logic signed [tsef_pkg::ECELL_WIDTH-1:0]   e_term;
    logic signed [tsef_pkg::FCELL_WIDTH-1:0]   f_term;

    logic signed [OW-1:0] r_site_energy, r_field_x, r_field_y, r_field_z;
    logic                 r_out_valid;

    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] a,
        input logic signed [ACC_WIDTH-1:0] b
    );
        logic signed [ACC_WIDTH:0] s;
        s = (ACC_WIDTH+1)'(a) + (ACC_WIDTH+1)'(b);
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
            sat_add = s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                   : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else begin
            sat_add = s[ACC_WIDTH-1:0];
        end
    endfunction

    // ---- input capture ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mi_x  <= i_spin_i_x;
            r_mi_y  <= i_spin_i_y;
            r_mi_z  <= i_spin_i_z;
            r_mj_x  <= i_spin_j_x;
            r_mj_y  <= i_spin_j_y;
            r_mj_z  <= i_spin_j_z;
            r_mk_x  <= i_spin_k_x;
            r_mk_y  <= i_spin_k_y;
            r_mk_z  <= i_spin_k_z;
            r_mjk_x <= SW1'(i_spin_j_x) + SW1'(i_spin_k_x);
            r_mjk_y <= SW1'(i_spin_j_y) + SW1'(i_spin_k_y);
            r_mjk_z <= SW1'(i_spin_j_z) + SW1'(i_spin_k_z);
        end
    end

    // ---- output operand prep: pick accumulator, clamp, split ----
    always_comb begin
        sel_acc = r_acc_e;
        sel_neg = 1'b0;
        unique case (i_cmd.op)
            tsef_pkg::OP_O_E_LO, tsef_pkg::OP_O_E_HI: begin
                sel_acc = r_acc_e;
                sel_neg = 1'b1;
            end
            tsef_pkg::OP_O_X_LO, tsef_pkg::OP_O_X_HI: sel_acc = r_acc_x;
            tsef_pkg::OP_O_Y_LO, tsef_pkg::OP_O_Y_HI: sel_acc = r_acc_y;
            tsef_pkg::OP_O_Z_LO, tsef_pkg::OP_O_Z_HI: sel_acc = r_acc_z;
            default: ;
        endcase
    end

    assign acc_x  = XW'(sel_acc);
    assign acc_cl = (acc_x > LIM_P) ? LIM_P : ((acc_x < LIM_N) ? LIM_N : acc_x);
    assign cl_lo  = {1'b0, acc_cl[tsef_pkg::SPLIT-1:0]};
    assign cl_hi  = acc_cl[tsef_pkg::LIM_WIDTH-1:tsef_pkg::SPLIT];
    assign coup_x = tsef_pkg::CA_WIDTH'(i_coupling);
    assign coup_a = sel_neg ? -coup_x : coup_x;

    // ---- operand select ----
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (i_cmd.op)
            tsef_pkg::OP_IJ_X:   begin op_a = MW'(r_mi_x); op_b = MW'(r_mj_x); end
            tsef_pkg::OP_IJ_Y:   begin op_a = MW'(r_mi_y); op_b = MW'(r_mj_y); end
            tsef_pkg::OP_IJ_Z:   begin op_a = MW'(r_mi_z); op_b = MW'(r_mj_z); end
            tsef_pkg::OP_IK_X:   begin op_a = MW'(r_mi_x); op_b = MW'(r_mk_x); end
            tsef_pkg::OP_IK_Y:   begin op_a = MW'(r_mi_y); op_b = MW'(r_mk_y); end
            tsef_pkg::OP_IK_Z:   begin op_a = MW'(r_mi_z); op_b = MW'(r_mk_z); end
            tsef_pkg::OP_JK_X:   begin op_a = MW'(r_mj_x); op_b = MW'(r_mk_x); end
            tsef_pkg::OP_JK_Y:   begin op_a = MW'(r_mj_y); op_b = MW'(r_mk_y); end
            tsef_pkg::OP_JK_Z:   begin op_a = MW'(r_mj_z); op_b = MW'(r_mk_z); end
            tsef_pkg::OP_E_IJIK: begin op_a = MW'(r_dij);  op_b = MW'(r_dik);  end
            tsef_pkg::OP_E_IJJK: begin op_a = MW'(r_dij);  op_b = MW'(r_djk);  end
            tsef_pkg::OP_E_IKJK: begin op_a = MW'(r_dik);  op_b = MW'(r_djk);  end
            tsef_pkg::OP_F_J_X:  begin op_a = MW'(r_mj_x);  op_b = MW'(r_dik); end
            tsef_pkg::OP_F_K_X:  begin op_a = MW'(r_mk_x);  op_b = MW'(r_dij); end
            tsef_pkg::OP_F_JK_X: begin op_a = MW'(r_mjk_x); op_b = MW'(r_djk); end
            tsef_pkg::OP_F_J_Y:  begin op_a = MW'(r_mj_y);  op_b = MW'(r_dik); end
            tsef_pkg::OP_F_K_Y:  begin op_a = MW'(r_mk_y);  op_b = MW'(r_dij); end
            tsef_pkg::OP_F_JK_Y: begin op_a = MW'(r_mjk_y); op_b = MW'(r_djk); end
            tsef_pkg::OP_F_J_Z:  begin op_a = MW'(r_mj_z);  op_b = MW'(r_dik); end
            tsef_pkg::OP_F_K_Z:  begin op_a = MW'(r_mk_z);  op_b = MW'(r_dij); end
            tsef_pkg::OP_F_JK_Z: begin op_a = MW'(r_mjk_z); op_b = MW'(r_djk); end
            tsef_pkg::OP_O_E_LO, tsef_pkg::OP_O_X_LO,
            tsef_pkg::OP_O_Y_LO, tsef_pkg::OP_O_Z_LO: begin
                op_a = MW'(coup_a);
                op_b = MW'(cl_lo);
            end
            tsef_pkg::OP_O_E_HI, tsef_pkg::OP_O_X_HI,
            tsef_pkg::OP_O_Y_HI, tsef_pkg::OP_O_Z_HI: begin
                op_a = MW'(coup_a);
                op_b = MW'(cl_hi);
            end
            default: ;
        endcase
    end

    // ---- shared multiplier ----
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(op_a) * PW'(op_b);
        r_pop  <= i_cmd.op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_cmd.issue;
        end
    end

    // ---- product post-processing (floor shifts) ----
    assign dsh      = (r_prod >>> DSH_R) <<< DSH_L;
    assign dot_term = dsh[tsef_pkg::DOT_WIDTH-1:0];
    assign esh      = r_prod >>> tsef_pkg::OUT_FRAC;
    assign e_term   = esh[tsef_pkg::ECELL_WIDTH-1:0];
    assign fsh      = r_prod >>> (SPIN_WIDTH - 1);
    assign f_term   = fsh[tsef_pkg::FCELL_WIDTH-1:0];

    // coupling * clamped = hi_prod * 2^24 + lo_prod, then floor by 8, saturate
    assign hp     = r_prod[tsef_pkg::HP_WIDTH-1:0];
    assign p_full = (QW'(hp) <<< tsef_pkg::SPLIT) + QW'(r_lo);
    assign p_shr  = p_full >>> tsef_pkg::COUP_FRAC;
    assign p_top  = p_shr[QW-1:OW-1];
    assign p_sat  = ((&p_top) || !(|p_top)) ? p_shr[OW-1:0]
                  : (p_shr[QW-1] ? OUT_MIN : OUT_MAX);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dij   <= '0;
            r_dik   <= '0;
            r_djk   <= '0;
            r_ecell <= '0;
            r_fx    <= '0;
            r_fy    <= '0;
            r_fz    <= '0;
        end else if (r_pvld) begin
            unique case (r_pop)
                tsef_pkg::OP_IJ_X, tsef_pkg::OP_IJ_Y, tsef_pkg::OP_IJ_Z:
                    r_dij <= r_dij + dot_term;
                tsef_pkg::OP_IK_X, tsef_pkg::OP_IK_Y, tsef_pkg::OP_IK_Z:
                    r_dik <= r_dik + dot_term;
                tsef_pkg::OP_JK_X, tsef_pkg::OP_JK_Y, tsef_pkg::OP_JK_Z:
                    r_djk <= r_djk + dot_term;
                tsef_pkg::OP_E_IJIK, tsef_pkg::OP_E_IJJK, tsef_pkg::OP_E_IKJK:
                    r_ecell <= r_ecell + e_term;
                tsef_pkg::OP_F_J_X, tsef_pkg::OP_F_K_X, tsef_pkg::OP_F_JK_X:
                    r_fx <= r_fx + f_term;
                tsef_pkg::OP_F_J_Y, tsef_pkg::OP_F_K_Y, tsef_pkg::OP_F_JK_Y:
                    r_fy <= r_fy + f_term;
                tsef_pkg::OP_F_J_Z, tsef_pkg::OP_F_K_Z, tsef_pkg::OP_F_JK_Z:
                    r_fz <= r_fz + f_term;
                tsef_pkg::OP_O_E_LO, tsef_pkg::OP_O_X_LO,
                tsef_pkg::OP_O_Y_LO, tsef_pkg::OP_O_Z_LO:
                    r_lo <= r_prod[tsef_pkg::HP_WIDTH-1:0];
                tsef_pkg::OP_O_E_HI: r_site_energy <= p_sat;
                tsef_pkg::OP_O_X_HI: r_field_x     <= p_sat;
                tsef_pkg::OP_O_Y_HI: r_field_y     <= p_sat;
                tsef_pkg::OP_O_Z_HI: r_field_z     <= p_sat;
                default: ;
            endcase
        end
    end

    // ---- accumulators ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_e <= '0;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_acc_z <= '0;
        end else if (i_cmd.commit) begin
            r_acc_e <= sat_add(r_acc_e, ACC_WIDTH'(r_ecell));
            r_acc_x <= sat_add(r_acc_x, ACC_WIDTH'(r_fx));
            r_acc_y <= sat_add(r_acc_y, ACC_WIDTH'(r_fy));
            r_acc_z <= sat_add(r_acc_z, ACC_WIDTH'(r_fz));
        end else if (i_cmd.finish) begin
            r_acc_e <= '0;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_acc_z <= '0;
        end
    end

    // ---- result word handshake ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_busy    = r_out_valid;
    assign o_site_energy = r_site_energy;
    assign o_field_x     = r_field_x;
    assign o_field_y     = r_field_y;
    assign o_field_z     = r_field_z;

endmodule

/* hw/rtl/three_spin_energy_and_field.sv */
// ============================================================================
// three_spin_energy_and_field
// Per-site three-spin interaction energy and effective field: accumulates
// cell terms over a site's cells and emits coupling-scaled, saturated results.
// ============================================================================
//
//  channel   signals                              dir   word
//  -------   -----------------------------------  ----  ------------------------
//  in        i_valid / o_ready                    in    9 spin comps + 2 flags
//  out       o_valid / i_ready                    out   energy + field x/y/z
//  cfg       psel penable pwrite paddr pwdata     in    coupling (addr 0)
//
//  Each valid cell runs 21 jobs on one shared multiplier (9 dot terms,
//  3 energy and 9 field products): accept, the job issues, drain, commit.
//  A skipped cell that is not last is only accepted. A last cell adds a
//  result-register check, 8 scaling multiplies and a drain.
//  Reset is synchronous, active low; coupling resets to 1.0 (256 in Q8.8).
//  Input is accepted while a result waits; a new result waits for the old one.
//
module three_spin_energy_and_field #(
    parameter int SPIN_WIDTH = tsef_pkg::SPIN_WIDTH,
    parameter int ACC_WIDTH  = tsef_pkg::ACC_WIDTH
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,

    // input word
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [SPIN_WIDTH-1:0]            i_spin_i_x,
    input  logic signed [SPIN_WIDTH-1:0]            i_spin_i_y,
    input  logic signed [SPIN_WIDTH-1:0]            i_spin_i_z,
    input  logic signed [SPIN_WIDTH-1:0]            i_spin_j_x,
    input  logic signed [SPIN_WIDTH-1:0]            i_spin_j_y,
    input  logic signed [SPIN_WIDTH-1:0]            i_spin_j_z,
    input  logic signed [SPIN_WIDTH-1:0]            i_spin_k_x,
    input  logic signed [SPIN_WIDTH-1:0]            i_spin_k_y,
    input  logic signed [SPIN_WIDTH-1:0]            i_spin_k_z,
    input  logic                                    i_cell_valid,
    input  logic                                    i_last_cell,

    // result word
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [tsef_pkg::OUT_WIDTH-1:0]   o_site_energy,
    output logic signed [tsef_pkg::OUT_WIDTH-1:0]   o_field_x,
    output logic signed [tsef_pkg::OUT_WIDTH-1:0]   o_field_y,
    output logic signed [tsef_pkg::OUT_WIDTH-1:0]   o_field_z,

    // APB configuration
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [tsef_pkg::APB_ADDR_WIDTH-1:0]     paddr,
    input  logic [tsef_pkg::APB_DATA_WIDTH-1:0]     pwdata,
    output logic [tsef_pkg::APB_DATA_WIDTH-1:0]     prdata,
    output logic                                    pready
);

    tsef_pkg::t_cmd                          cmd;
    logic                                    out_busy;
    logic signed [tsef_pkg::COUP_WIDTH-1:0]  coupling;

    // coupling register
    tsef_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_coupling (coupling)
    );

    // sequencer: accept, per-cell jobs, commit, output jobs
    tsef_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_cell_valid (i_cell_valid),
        .i_last_cell  (i_last_cell),
        .i_out_busy   (out_busy),
        .o_ready      (o_ready),
        .o_cmd        (cmd)
    );

    // multiplier, sums, accumulators, result register
    tsef_dp #(
        .SPIN_WIDTH (SPIN_WIDTH),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_spin_i_x    (i_spin_i_x),
        .i_spin_i_y    (i_spin_i_y),
        .i_spin_i_z    (i_spin_i_z),
        .i_spin_j_x    (i_spin_j_x),
        .i_spin_j_y    (i_spin_j_y),
        .i_spin_j_z    (i_spin_j_z),
        .i_spin_k_x    (i_spin_k_x),
        .i_spin_k_y    (i_spin_k_y),
        .i_spin_k_z    (i_spin_k_z),
        .i_coupling    (coupling),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_out_busy    (out_busy),
        .o_site_energy (o_site_energy),
        .o_field_x     (o_field_x),
        .o_field_y     (o_field_y),
        .o_field_z     (o_field_z)
    );

endmodule
